// File: hdl/wfgcd_pkg.sv
// Shared types and constants for the wait-for graph cycle detector.
package wfgcd_pkg;

    // Width of a node number in an input or output word
    localparam int unsigned NODE_FIELD_W = 3;
    localparam int unsigned S_TDATA_W    = 8;
    localparam int unsigned M_TDATA_W    = 8;

    typedef enum logic {
        OP_WRITE_EDGE = 1'b0,
        OP_CHECK      = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_REPORT
    } state_t;

endpackage

// File: hdl/wait_for_graph_cycle_detector_unit.sv
// Wait-for graph cycle detector: adjacency matrix plus iterative depth-first search.
//
// Keeps a directed graph of NODE_COUNT nodes as an adjacency bit matrix in
// flip-flops (no edges after reset). An input word with tuser = 0 sets or
// clears one edge (from_node -> to_node) and produces no output word; it is
// absorbed in the cycle it is accepted, so edge writes stream at one per
// clock. An input word with tuser = 1 runs a depth-first search from
// from_node and produces one output word: cycle_found plus the start node.
// The search is done by a single scan unit that tests one adjacency bit per
// clock, under a small sequencer with an explicit stack of (node, next
// neighbor) entries. A check runs through setup, then a search that scans
// neighbor positions and pops the stack, then report; the search ends early
// when a cycle is found, and it scans only reachable nodes. The input is
// not ready while a check is in flight. The result sits in an output
// register, so a new word is accepted while a result waits on m_tready; a
// second check only stalls at its end if the previous result is still
// unclaimed. Node fields are 3 bits wide; writes naming a node at or above
// NODE_COUNT are dropped, and a check from such a node reports no cycle.
module wait_for_graph_cycle_detector_unit #(
    parameter int unsigned NODE_COUNT = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: [2:0] from_node, [5:3] to_node, [6] edge_present, [7] zero
    input  logic [wfgcd_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: [0] operation (0 write edge, 1 check)
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: [0] cycle_found, [3:1] start_echo, [7:4] zero
    output logic [wfgcd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready
);

    localparam int unsigned NW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1; // node index
    localparam int unsigned SW  = $clog2(NODE_COUNT + 1);                     // scan 0..N
    localparam int unsigned SPW = $clog2(NODE_COUNT + 1);                     // stack ptr 0..N
    localparam int unsigned FW  = wfgcd_pkg::NODE_FIELD_W;
    localparam logic [NODE_COUNT-1:0] ONE_HOT = NODE_COUNT'(1);

    // ---------------------------------------------------------------
    // Input word unpacking
    // ---------------------------------------------------------------
    logic [FW-1:0]   in_from;
    logic [FW-1:0]   in_to;
    logic            in_present;
    wfgcd_pkg::op_t  in_op;
    logic            in_accept;
    logic            from_in_range;
    logic            to_in_range;

    assign in_from       = s_tdata[FW-1:0];
    assign in_to         = s_tdata[2*FW-1:FW];
    assign in_present    = s_tdata[2*FW];
    assign in_op         = wfgcd_pkg::op_t'(s_tuser);
    assign in_accept     = s_tvalid && s_tready;
    assign from_in_range = 32'(in_from) < NODE_COUNT;
    assign to_in_range   = 32'(in_to) < NODE_COUNT;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    wfgcd_pkg::state_t state_reg, state_next;

    logic [NODE_COUNT-1:0] adj_reg [NODE_COUNT];    // row u, bit v: edge u -> v
    logic [NODE_COUNT-1:0] visited_reg, visited_next;
    logic [NODE_COUNT-1:0] on_stack_reg, on_stack_next;
    logic [SPW-1:0]        sp_reg, sp_next;

    // Stack of suspended entries below the top; the top lives in cur_*
    logic [NW-1:0]         stk_node_mem [NODE_COUNT];
    logic [SW-1:0]         stk_scan_mem [NODE_COUNT];

    logic [NW-1:0]         cur_node_reg, cur_node_next;
    logic [SW-1:0]         cur_scan_reg, cur_scan_next;
    logic                  found_reg, found_next;
    logic [FW-1:0]         start_reg, start_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_found_reg;
    logic [FW-1:0]         m_start_reg;

    // ---------------------------------------------------------------
    // Scan unit: tests one adjacency bit per cycle
    // ---------------------------------------------------------------
    logic [NW-1:0]         scan_idx;
    logic                  scan_end;
    logic                  scan_hit;
    logic [NODE_COUNT-1:0] scan_bit;
    logic [SW-1:0]         scan_inc;
    logic                  search_done;
    logic                  stk_push;
    logic [NW-1:0]         stk_wr_idx;
    logic [NW-1:0]         stk_rd_idx;
    logic                  out_free;
    logic                  load_out;

    assign scan_idx   = cur_scan_reg[NW-1:0];
    assign scan_end   = 32'(cur_scan_reg) >= NODE_COUNT;
    assign scan_hit   = !scan_end && adj_reg[cur_node_reg][scan_idx];
    assign scan_bit   = ONE_HOT << scan_idx;
    assign scan_inc   = cur_scan_reg + SW'(1);
    assign stk_wr_idx = NW'(sp_reg - SPW'(1));
    assign stk_rd_idx = NW'(sp_reg - SPW'(2));
    assign out_free   = !m_valid_reg || m_tready;

    // Done when the last entry pops, or an edge lands on a node on the stack
    assign search_done = (scan_end && (sp_reg == SPW'(1)))
                       || (scan_hit && ((on_stack_reg & scan_bit) != '0));

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wfgcd_pkg::ST_IDLE: begin
                if (in_accept && (in_op == wfgcd_pkg::OP_CHECK)) begin
                    state_next = from_in_range ? wfgcd_pkg::ST_SEARCH
                                               : wfgcd_pkg::ST_REPORT;
                end
            end
            wfgcd_pkg::ST_SEARCH: begin
                if (search_done) begin
                    state_next = wfgcd_pkg::ST_REPORT;
                end
            end
            wfgcd_pkg::ST_REPORT: begin
                if (out_free) begin
                    state_next = wfgcd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wfgcd_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            wfgcd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            wfgcd_pkg::ST_REPORT: begin
                load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Search datapath
    // ---------------------------------------------------------------
    always_comb begin
        visited_next  = visited_reg;
        on_stack_next = on_stack_reg;
        sp_next       = sp_reg;
        cur_node_next = cur_node_reg;
        cur_scan_next = cur_scan_reg;
        found_next    = found_reg;
        start_next    = start_reg;
        stk_push      = 1'b0;

        if (state_reg == wfgcd_pkg::ST_IDLE) begin
            if (in_accept && (in_op == wfgcd_pkg::OP_CHECK)) begin
                start_next = in_from;
                found_next = 1'b0;
                if (from_in_range) begin
                    visited_next  = ONE_HOT << NW'(in_from);
                    on_stack_next = ONE_HOT << NW'(in_from);
                    cur_node_next = NW'(in_from);
                    cur_scan_next = '0;
                    sp_next       = SPW'(1);
                end
            end
        end else if (state_reg == wfgcd_pkg::ST_SEARCH) begin
            if (scan_end) begin
                // pop: node leaves the stack, parent resumes
                on_stack_next = on_stack_reg & ~(ONE_HOT << cur_node_reg);
                sp_next       = sp_reg - SPW'(1);
                if (sp_reg != SPW'(1)) begin
                    cur_node_next = stk_node_mem[stk_rd_idx];
                    cur_scan_next = stk_scan_mem[stk_rd_idx];
                end
            end else if (!scan_hit) begin
                cur_scan_next = scan_inc;
            end else if ((on_stack_reg & scan_bit) != '0) begin
                found_next = 1'b1;   // back edge, self-loop included
            end else if ((visited_reg & scan_bit) == '0) begin
                visited_next  = visited_reg | scan_bit;
                on_stack_next = on_stack_reg | scan_bit;
                if (32'(sp_reg) < NODE_COUNT) begin
                    stk_push      = 1'b1;
                    sp_next       = sp_reg + SPW'(1);
                    cur_node_next = scan_idx;
                    cur_scan_next = '0;
                end else begin
                    cur_scan_next = scan_inc;
                end
            end else begin
                cur_scan_next = scan_inc;   // already finished node
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(wfgcd_pkg::M_TDATA_W - FW - 1){1'b0}}, m_start_reg, m_found_reg};

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wfgcd_pkg::ST_IDLE;
            visited_reg  <= '0;
            on_stack_reg <= '0;
            sp_reg       <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NODE_COUNT; i++) begin
                adj_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            visited_reg  <= visited_next;
            on_stack_reg <= on_stack_next;
            sp_reg       <= sp_next;
            m_valid_reg  <= m_valid_next;
            if ((state_reg == wfgcd_pkg::ST_IDLE) && in_accept
                    && (in_op == wfgcd_pkg::OP_WRITE_EDGE)
                    && from_in_range && to_in_range) begin
                adj_reg[NW'(in_from)][NW'(in_to)] <= in_present;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_node_reg <= cur_node_next;
        cur_scan_reg <= cur_scan_next;
        found_reg    <= found_next;
        start_reg    <= start_next;
        if (stk_push) begin
            // suspended parent resumes after the neighbor just taken
            stk_node_mem[stk_wr_idx] <= cur_node_reg;
            stk_scan_mem[stk_wr_idx] <= scan_inc;
        end
        if (load_out) begin
            m_found_reg <= found_reg;
            m_start_reg <= start_reg;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`ifndef ASSERT_OFF
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sp_reg) <= NODE_COUNT)
        else $error("stack pointer beyond node count");

    a_top_on_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wfgcd_pkg::ST_SEARCH) |-> on_stack_reg[cur_node_reg])
        else $error("search top node not marked on stack");

    a_stack_in_visited: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wfgcd_pkg::ST_SEARCH) |-> ((on_stack_reg & ~visited_reg) == '0))
        else $error("on-stack node not marked visited");

    a_oor_no_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_found_reg) |-> (32'(m_start_reg) < NODE_COUNT))
        else $error("cycle reported from out-of-range start node");
`endif

endmodule

// File: verif/wfgcd_result_checker.sv
// Checker for the wait-for graph cycle detector: mirrors the graph, predicts check results, compares.
module wfgcd_result_checker #(
    parameter int unsigned NODES = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [wfgcd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [wfgcd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    output int                               error_count,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       cycle_found;
        logic [2:0] start_echo;
    } verdict_t;

    logic [NODES-1:0] edge_rows [NODES];
    verdict_t         pending_verdicts [$];

    task automatic report(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // Iterative DFS over the mirrored matrix; hits a cycle on any edge back into the path
    function automatic logic cycle_reachable(input logic [2:0] start);
        logic [NODES-1:0] visited;
        logic [NODES-1:0] on_path;
        int               path_node [NODES];
        int               path_scan [NODES];
        int               depth;
        int               u;
        int               v;
        logic             hit;
        if (start >= NODES)
            return 1'b0;
        visited      = '0;
        on_path      = '0;
        visited[start] = 1'b1;
        on_path[start] = 1'b1;
        path_node[0] = start;
        path_scan[0] = 0;
        depth        = 1;
        hit          = 1'b0;
        while (depth > 0 && !hit) begin
            u = path_node[depth-1];
            v = path_scan[depth-1];
            while (v < NODES && !edge_rows[u][v])
                v++;
            if (v >= NODES) begin
                on_path[u] = 1'b0;
                depth--;
            end else begin
                path_scan[depth-1] = v + 1;
                if (on_path[v]) begin
                    hit = 1'b1;
                end else if (!visited[v]) begin
                    visited[v] = 1'b1;
                    on_path[v] = 1'b1;
                    if (depth < NODES) begin
                        path_node[depth] = v;
                        path_scan[depth] = 0;
                        depth++;
                    end
                end
            end
        end
        return hit;
    endfunction

    always @(posedge aclk) begin
        logic [2:0] src;
        logic [2:0] dst;
        verdict_t   want;
        src = s_tdata[2:0];
        dst = s_tdata[5:3];
        if (!aresetn) begin
            for (int i = 0; i < NODES; i++)
                edge_rows[i] = '0;
            pending_verdicts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    report("unexpected result word", m_tdata, 0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_tdata[0] !== want.cycle_found)
                        report("cycle_found", m_tdata[0], want.cycle_found);
                    if (m_tdata[3:1] !== want.start_echo)
                        report("start_echo", m_tdata[3:1], want.start_echo);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == wfgcd_pkg::OP_CHECK) begin
                    want.cycle_found = cycle_reachable(src);
                    want.start_echo  = src;
                    pending_verdicts.push_back(want);
                end else if (src < NODES && dst < NODES) begin
                    edge_rows[src][dst] = s_tdata[6];
                end
            end
        end
        outstanding <= pending_verdicts.size();
    end

endmodule

// File: verif/wait_for_graph_cycle_detector_unit_test.sv
// Top of the cycle detector testbench: clock, reset, stimulus, stalls, watchdog and verdict.
module wait_for_graph_cycle_detector_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // A check plus the stall bursts on each side is far shorter than this, so
    // this many cycles without any handshake means the block is hung.
    localparam int STUCK_LIMIT   = 5000;
    // Grace period once the last result is in, covering one full check.
    localparam int DRAIN_CYCLES  = 120;
    localparam int RANDOM_WORDS  = 1500;
    // The tail of the random part runs with both sides always ready.
    localparam int QUIET_TAIL    = 200;
    localparam int SEGMENT_WORDS = 100;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic [wfgcd_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                             s_tuser  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [wfgcd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;

    int   error_count;
    int   outstanding;
    int   stuck_cycles = 0;
    // Shared by sender and receiver: when low, neither side inserts idle bursts
    logic idle_enable  = 1'b1;

    initial begin
        forever #4 aclk = ~aclk;
    end

    wait_for_graph_cycle_detector_unit #(
        .NODE_COUNT(8)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    wfgcd_result_checker #(
        .NODES(8)
    ) cycle_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // Present one word and hold it until taken; maybe follow with an idle burst.
    // tdata: [2:0] from, [5:3] to, [6] edge_present, [7] pad
    task automatic send_word(input wfgcd_pkg::op_t op, input logic [2:0] src,
                             input logic [2:0] dst, input logic present);
        s_tdata  <= {1'b0, present, dst, src};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic set_edge(input logic [2:0] src, input logic [2:0] dst, input logic present);
        send_word(wfgcd_pkg::OP_WRITE_EDGE, src, dst, present);
    endtask

    task automatic check_from(input logic [2:0] start);
        // to and edge_present are don't-care on a check; randomize them anyway
        send_word(wfgcd_pkg::OP_CHECK, start, 3'($urandom), 1'($urandom));
    endtask

    // Receiver back-pressure: random stall bursts
    initial begin
        while (!aresetn)
            @(posedge aclk);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (idle_enable && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any handshake on either side counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("wait_for_graph_cycle_detector_unit test failed");
            $finish;
        end
    end

    initial begin
        int         mode;
        int         density;
        logic [2:0] src;
        logic [2:0] dst;
        logic       present;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---
        check_from(3'd0);                   // empty graph, no cycle
        check_from(3'd7);
        set_edge(3'd7, 3'd7, 1'b1);          // self-loop on the top node
        check_from(3'd7);
        set_edge(3'd7, 3'd7, 1'b0);
        check_from(3'd7);
        set_edge(3'd0, 3'd1, 1'b1);          // 0 -> 1 -> 2 -> 0 ring
        set_edge(3'd1, 3'd2, 1'b1);
        set_edge(3'd2, 3'd0, 1'b1);
        check_from(3'd0);
        check_from(3'd2);
        check_from(3'd3);                   // ring not reachable from 3
        set_edge(3'd3, 3'd0, 1'b1);
        check_from(3'd3);                   // ring reachable through 3
        set_edge(3'd2, 3'd0, 1'b0);          // break the ring
        check_from(3'd3);
        set_edge(3'd5, 3'd6, 1'b0);          // clearing an absent edge
        set_edge(3'd2, 3'd7, 1'b1);          // diamond-ish DAG, 7 reached twice
        set_edge(3'd0, 3'd7, 1'b1);
        check_from(3'd0);
        set_edge(3'd7, 3'd3, 1'b1);          // back into the path, long cycle
        check_from(3'd1);
        check_from(3'd4);

        // --- random part, in segments of different flavor ---
        // mode 0: uniform edits at a per-segment set density
        // mode 1: edges only point upward (acyclic), with rare back edges
        // mode 2: mostly clears, drives the graph back toward empty
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % SEGMENT_WORDS == 0) begin
                mode        = $urandom_range(0, 2);
                density     = $urandom_range(5, 70);
            end
            if (n >= RANDOM_WORDS - QUIET_TAIL)
                idle_enable <= 1'b0;
            else if (n % SEGMENT_WORDS == 0)
                idle_enable <= ($urandom_range(0, 3) != 0);

            src = 3'($urandom);
            dst = 3'($urandom);
            if ($urandom_range(0, 99) < 35) begin
                check_from(src);
            end else begin
                case (mode)
                    0: begin
                        present = ($urandom_range(0, 99) < density);
                    end
                    1: begin
                        present = (dst > src) ? ($urandom_range(0, 99) < 60)
                                              : ($urandom_range(0, 99) < 4);
                    end
                    default: begin
                        present = ($urandom_range(0, 99) < 10);
                    end
                endcase
                set_edge(src, dst, present);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && outstanding == 0) begin
            $display("wait_for_graph_cycle_detector_unit test passed");
        end else begin
            $display("wait_for_graph_cycle_detector_unit test failed");
        end
        $finish;
    end

endmodule
